>>> sv/cnw_pkg.sv
// Package with the word and result types and the cell control group.
`default_nettype none

package cnw_pkg;

  localparam int unsigned IN_SYM_W = 8;
  localparam int unsigned OUT_W = 9;

  typedef struct packed {
    logic [IN_SYM_W-1:0] symbol;
    logic                last;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] exponent;
    logic [OUT_W-1:0] min_period;
    logic             too_long;
  } out_word_t;

  // Cell controls; at most one of them is high in a cycle.
  typedef struct packed {
    logic init;
    logic load;
    logic cmp;
    logic drain;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/cnw_cell.sv
// One cell of the chain: a stored symbol and the repeat count for one period.
`default_nettype none

module cnw_cell #(
  parameter int unsigned PERIOD = 1,
  parameter int unsigned SYM_W = 8,
  parameter int unsigned MAX_LEN = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cnw_pkg::cell_ctrl_t             ctrl,
  input  wire logic [SYM_W-1:0]                lo_sym,
  input  wire logic                            lo_vld,
  input  wire logic [SYM_W-1:0]                hi_sym,
  input  wire logic                            hi_vld,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]    hi_copies,
  input  wire logic [SYM_W-1:0]                head_sym,
  output logic [SYM_W-1:0]                     sym,
  output logic                                 vld,
  output logic [$clog2(MAX_LEN+1)-1:0]         copies
);
  import cnw_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN+1);
  localparam logic [PW-1:0] POS_LAST = PW'(PERIOD - 1);

  logic          alive;
  logic [PW-1:0] pos;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sym <= lo_sym;
    end else if (ctrl.cmp) begin
      sym <= hi_sym;
    end
  end

  // During the compare pass the head holds w[i+PERIOD] while this cell holds w[i],
  // with i walking down from the end of the word. A run of matches that fills
  // a whole period adds one more copy of the final block.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= 1'b0;
      alive  <= 1'b1;
      pos    <= '0;
      copies <= CW'(1);
    end else if (ctrl.init) begin
      vld    <= 1'b0;
      alive  <= 1'b1;
      pos    <= '0;
      copies <= CW'(1);
    end else if (ctrl.load) begin
      vld <= lo_vld;
    end else if (ctrl.cmp) begin
      vld <= hi_vld;
      if (vld && alive) begin
        if (sym == head_sym) begin
          if (pos == POS_LAST) begin
            pos    <= '0;
            copies <= copies + CW'(1);
          end else begin
            pos <= pos + PW'(1);
          end
        end else begin
          alive <= 1'b0;
        end
      end
    end else if (ctrl.drain) begin
      copies <= hi_copies;
    end
  end

endmodule

`default_nettype wire

>>> sv/curling_number_of_word_unit.sv
// Top level: loader, chain of period cells, result scan and output register.
`default_nettype none

// A word is taken one symbol per cycle while item_ready is high; symbols past
// MAX_LEN are dropped and flagged in too_long. The word marked last starts the
// work: a compare pass, in which the stored word shifts down the chain of
// MAX_LEN-1 period cells and each cell matches its symbol against the head,
// then a scan that shifts the per-period counts out of the chain into the
// max/least-period tracker. Input is held off from the last symbol until the
// result is registered. The result register then waits for res_ready while the
// next word loads.
module curling_number_of_word_unit #(
  parameter int unsigned MAX_LEN = 256,
  parameter int unsigned SYMBOL_WIDTH = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire cnw_pkg::in_word_t   item,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output cnw_pkg::out_word_t       res
);
  import cnw_pkg::*;

  localparam int unsigned NW = $clog2(MAX_LEN+1);
  localparam int unsigned SW = (SYMBOL_WIDTH < IN_SYM_W) ? SYMBOL_WIDTH : IN_SYM_W;
  localparam logic [NW-1:0] FULL = NW'(MAX_LEN);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_CMP   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t        state;
  logic [NW-1:0] len;
  logic          ovf;
  logic [SW-1:0] head_sym;
  logic          head_vld;
  logic [NW-1:0] scan_p;
  logic [NW-1:0] best;
  logic [NW-1:0] least;

  logic [SW-1:0] c_sym    [0:MAX_LEN];
  logic          c_vld    [0:MAX_LEN];
  logic [NW-1:0] c_copies [1:MAX_LEN];

  cell_ctrl_t ctrl;
  logic       accept;
  logic       store_ok;
  logic       scan_active;
  logic       finish;

  assign item_ready  = (state == S_LOAD);
  assign accept      = item_valid && item_ready;
  assign store_ok    = (len != FULL);
  assign scan_active = (scan_p < len);
  assign finish      = (state == S_DRAIN) && !scan_active && (!res_valid || res_ready);

  assign ctrl.init  = finish;
  assign ctrl.load  = accept && store_ok;
  assign ctrl.cmp   = (state == S_CMP) && c_vld[1];
  assign ctrl.drain = (state == S_DRAIN) && scan_active;

  assign c_sym[0]          = head_sym;
  assign c_vld[0]          = head_vld;
  assign c_sym[MAX_LEN]    = '0;
  assign c_vld[MAX_LEN]    = 1'b0;
  assign c_copies[MAX_LEN] = NW'(1);

  for (genvar j = 1; j < MAX_LEN; j++) begin : g_cell
    cnw_cell #(
      .PERIOD (j),
      .SYM_W  (SW),
      .MAX_LEN(MAX_LEN)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .lo_sym   (c_sym[j-1]),
      .lo_vld   (c_vld[j-1]),
      .hi_sym   (c_sym[j+1]),
      .hi_vld   (c_vld[j+1]),
      .hi_copies(c_copies[j+1]),
      .head_sym (head_sym),
      .sym      (c_sym[j]),
      .vld      (c_vld[j]),
      .copies   (c_copies[j])
    );
  end

  // Head of the chain: newest symbol while loading, cell 1 during the compare pass.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      head_sym <= item.symbol[SW-1:0];
    end else if (ctrl.cmp) begin
      head_sym <= c_sym[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= 1'b0;
    end else if (ctrl.init) begin
      head_vld <= 1'b0;
    end else if (ctrl.load) begin
      head_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      len       <= '0;
      ovf       <= 1'b0;
      scan_p    <= NW'(1);
      best      <= NW'(1);
      least     <= NW'(1);
      res_valid <= 1'b0;
    end else begin
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              len <= len + NW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (item.last) begin
              state  <= S_CMP;
              scan_p <= NW'(1);
              best   <= NW'(1);
              least  <= NW'(1);
            end
          end
        end
        S_CMP: begin
          if (!c_vld[1]) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Periods arrive in increasing order, so a strict compare keeps the least.
          if (scan_active) begin
            if (c_copies[1] > best) begin
              best  <= c_copies[1];
              least <= scan_p;
            end
            scan_p <= scan_p + NW'(1);
          end else if (finish) begin
            len       <= '0;
            ovf       <= 1'b0;
            state     <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res.exponent   <= OUT_W'(best);
      res.min_period <= OUT_W'(least);
      res.too_long   <= ovf;
    end
  end

endmodule

`default_nettype wire

>>> sv/cnw_check.sv
// Port-level checker for the curling number unit, bound to the top level.
`default_nettype none

module cnw_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_ready,
  input wire cnw_pkg::in_word_t  item,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire cnw_pkg::out_word_t res
);
  import cnw_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed or dropped while stalled");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.last |=> !item_ready)
    else $error("input still taken after the last word of a word sequence");

  a_res_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.exponent != '0 && res.min_period != '0)
    else $error("result word has a zero exponent or root");

  a_res_reopens: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> item_ready && !$past(item_ready))
    else $error("new result without the input reopening");

endmodule

bind curling_number_of_word_unit cnw_check u_cnw_check (.*);

`default_nettype wire

>>> tb/curling_number_of_word_unit_tb.sv
// Self-checking testbench for the curling number unit, with random handshake stalls.
`timescale 1ns / 100ps
`default_nettype none

module curling_number_of_word_unit_tb;
  import cnw_pkg::*;

  localparam int unsigned WORD_CAP = 256;
  localparam int unsigned IDX_W = $clog2(WORD_CAP);
  localparam int unsigned SYM_BITS = 8;
  localparam int unsigned STALL_LIMIT = 8000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned HOLD_AFTER = 20;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned ITEM_TARGET = 1050;

  typedef logic [SYM_BITS-1:0] sym_list_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_word_t item = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_word_t res;

  // Stimulus and expected results.
  in_word_t symbol_feed[$];
  out_word_t curling_due[$];
  int unsigned total_items;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  // Predictor state: the symbol string collected so far.
  logic [SYM_BITS-1:0] word_syms[0:WORD_CAP-1];
  int unsigned word_len = 0;
  bit word_overflow = 1'b0;

  int unsigned feed_gap = 0;
  int unsigned drain_gap = 0;
  int unsigned backpressure_left = 0;
  bit backpressure_done = 1'b0;
  int unsigned idle_cycles = 0;
  bit drv_calm = 1'b0;
  bit mon_calm = 1'b0;

  curling_number_of_word_unit #(
    .MAX_LEN(WORD_CAP),
    .SYMBOL_WIDTH(SYM_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned idle_span(bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Largest count of repeated final blocks over all periods, and the least period giving it.
  function automatic out_word_t curling_of(int unsigned n, bit ovf);
    int unsigned best;
    int unsigned least;
    int unsigned copies;
    int unsigned p;
    int unsigned k;
    int unsigned j;
    bit same;
    out_word_t r;
    best = 1;
    least = n;
    for (p = 1; p <= n; p++) begin
      copies = 1;
      for (k = 2; k * p <= n; k++) begin
        same = 1'b1;
        for (j = 0; j < p; j++) begin
          if (word_syms[IDX_W'(n - k * p + j)] != word_syms[IDX_W'(n - p + j)]) same = 1'b0;
        end
        if (!same) break;
        copies++;
      end
      if (copies > best) begin
        best = copies;
        least = p;
      end else if (copies == best && p < least) begin
        least = p;
      end
    end
    r.exponent = best[OUT_W-1:0];
    r.min_period = least[OUT_W-1:0];
    r.too_long = ovf;
    return r;
  endfunction

  task automatic take_symbol(in_word_t w);
    out_word_t r;
    if (word_len < WORD_CAP) begin
      word_syms[IDX_W'(word_len)] = w.symbol;
      word_len++;
    end else begin
      word_overflow = 1'b1;
    end
    if (w.last) begin
      r = curling_of(word_len, word_overflow);
      curling_due = {curling_due, r};
      word_len = 0;
      word_overflow = 1'b0;
    end
  endtask

  task automatic queue_word(sym_list_t s);
    in_word_t w;
    for (int i = 0; i < s.size(); i++) begin
      w.symbol = s[i];
      w.last = (i == s.size() - 1);
      symbol_feed = {symbol_feed, w};
    end
  endtask

  task automatic flag_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    mismatches++;
  endtask

  // Sender: a new word goes out once the previous one is taken and its gap has run out.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      feed_gap <= 0;
    end else begin
      if (item_valid && item_ready) begin
        take_symbol(item);
        items_taken <= items_taken + 1;
      end
      if (item_valid && !item_ready) begin
        // Hold the word until it is taken.
      end else if (feed_gap != 0) begin
        feed_gap <= feed_gap - 1;
        item_valid <= 1'b0;
      end else if (symbol_feed.size() != 0) begin
        item <= symbol_feed.pop_front();
        item_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
        feed_gap <= idle_span(drv_calm);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result word and then stalls for a drawn number of cycles.
  always @(posedge clk) begin
    out_word_t want;
    int unsigned s;
    if (rst) begin
      res_ready <= 1'b0;
      drain_gap <= 0;
    end else begin
      s = drain_gap;
      if (res_valid && res_ready) begin
        results_seen <= results_seen + 1;
        if (curling_due.size() == 0) begin
          flag_mismatch("result with nothing pending", res.exponent, '0);
        end else begin
          want = curling_due.pop_front();
          if (res.exponent !== want.exponent)
            flag_mismatch("exponent", res.exponent, want.exponent);
          if (res.min_period !== want.min_period)
            flag_mismatch("min_period", res.min_period, want.min_period);
          if (res.too_long !== want.too_long)
            flag_mismatch("too_long", OUT_W'(res.too_long), OUT_W'(want.too_long));
        end
        if ($urandom_range(0, 39) == 0) mon_calm = !mon_calm;
        s = idle_span(mon_calm);
      end else if (s != 0) begin
        s = s - 1;
      end
      drain_gap <= s;
      res_ready <= (s == 0) && (backpressure_left == 0);
    end
  end

  // One long receiver hold-off so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      backpressure_left <= 0;
      backpressure_done <= 1'b0;
    end else if (backpressure_left != 0) begin
      backpressure_left <= backpressure_left - 1;
    end else if (!backpressure_done && results_seen == HOLD_AFTER) begin
      backpressure_left <= HOLD_CYCLES;
      backpressure_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_valid && item_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    sym_list_t w;
    logic [SYM_BITS-1:0] root[$];
    logic [SYM_BITS-1:0] alpha[0:2];
    logic [SYM_BITS-1:0] fill;
    int unsigned kind;
    int unsigned rlen;
    int unsigned reps;
    bit long_flat_done;
    bit long_cycle_done;

    // Directed strings: single extremes, a square, a cube, and a tie broken by the least period.
    queue_word('{8'd0});
    queue_word('{8'd255});
    queue_word('{8'd255, 8'd255});
    queue_word('{8'd1, 8'd2, 8'd1, 8'd2, 8'd1, 8'd2});
    queue_word('{8'd0, 8'd1, 8'd0});
    queue_word('{8'd7, 8'd9, 8'd7, 8'd7, 8'd9, 8'd7});
    queue_word('{8'hAA, 8'h55, 8'hAA, 8'h55});

    long_flat_done = 1'b0;
    long_cycle_done = 1'b0;
    while (symbol_feed.size() < ITEM_TARGET) begin
      w = {};
      if (!long_flat_done && symbol_feed.size() > 300) begin
        // A full store of one symbol, then a last symbol that is dropped.
        long_flat_done = 1'b1;
        fill = SYM_BITS'($urandom_range(0, 255));
        repeat (WORD_CAP) w = {w, fill};
        w = {w, SYM_BITS'($urandom_range(0, 255))};
      end else if (!long_cycle_done && symbol_feed.size() > 650) begin
        // Exactly fills the store, so nothing is dropped.
        long_cycle_done = 1'b1;
        rlen = $urandom_range(2, 7);
        root = {};
        repeat (rlen) root = {root, SYM_BITS'($urandom_range(0, 255))};
        for (int i = 0; i < WORD_CAP; i++) w = {w, root[i % rlen]};
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          // Repeated root over a small alphabet, after a short random prefix.
          for (int i = 0; i < 3; i++) alpha[2'(i)] = SYM_BITS'($urandom_range(0, 255));
          rlen = $urandom_range(1, 6);
          root = {};
          repeat (rlen) root = {root, alpha[2'($urandom_range(0, 2))]};
          repeat ($urandom_range(0, 4)) w = {w, alpha[2'($urandom_range(0, 2))]};
          reps = $urandom_range(1, 24 / rlen);
          repeat (reps) for (int i = 0; i < rlen; i++) w = {w, root[i]};
          if ($urandom_range(0, 3) == 0) w[w.size() - 1] = SYM_BITS'($urandom_range(0, 255));
        end else if (kind < 85) begin
          alpha[0] = SYM_BITS'($urandom_range(0, 255));
          alpha[1] = SYM_BITS'($urandom_range(0, 255));
          repeat ($urandom_range(1, 16)) w = {w, alpha[2'($urandom_range(0, 1))]};
        end else begin
          repeat ($urandom_range(1, 12)) w = {w, SYM_BITS'($urandom_range(0, 255))};
        end
      end
      queue_word(w);
    end
    total_items = symbol_feed.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!(items_taken == total_items && curling_due.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
